/* sv/kps_pkg.sv */
// Shared types, constants and helpers for the KMP pattern search unit.
package kps_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 16;
    localparam int PIDX_W     = 5;
    localparam int PAT_BYTES  = 32;
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT3   = 3'd4;

    // Failure link value that means "restart the match from scratch".
    localparam logic [LEN_W-1:0] K_RESTART = 6'h3F;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              first_of_text;
        logic              last_of_text;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
    } t_out_word;

    // Selects one pattern byte from the packed pattern vector.
    function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                   input logic [PIDX_W-1:0] idx);
        pat_byte = pat[{idx, 3'b000} +: BYTE_W];
    endfunction

endpackage

/* sv/kps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module kps_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/kmp_pattern_search_unit.sv */
// Top level of the streaming KMP pattern search unit.
//
// Usage: text words enter on the input channel (i_in_valid / o_in_stall), one
// byte per word, with flags for the first and the last byte of a text. The
// pattern and its length are set through the write port while the unit is
// idle. One result word leaves on the output channel (o_out_valid /
// i_out_stall) for each text: on the first full match, or at the last byte
// when the pattern never matched. Words after a result are absorbed quietly
// until the next first-of-text word.
// A byte is accepted only in the idle state and is then compared; every
// failure link followed adds one read of the failure table memory
// (registered read data) and another compare. Bytes after a result are only
// accepted. A first-of-text byte, or any byte after a configuration write,
// first rebuilds the failure table, one step at a time with an extra state
// per memory read. A result enters the output register at its compare, or
// from the pending register in the hold state while that register is
// occupied. Reset returns to idle with an empty output register, length 1,
// a zero pattern and the table marked unbuilt. When the receiver stalls, the
// result word holds; the unit keeps accepting bytes and only waits if a
// second result is ready before the first one is taken.
module kmp_pattern_search_unit
    import kps_pkg::*;
#(
    parameter int              MAX_PATTERN = 32,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam longint unsigned POS_LIM_L = (MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIM_L);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_PATTERN);

    // One-hot sequencer states. The B states build the table, the S states
    // walk the text byte through the failure links.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_BINIT = 9'b000000010,
        ST_BCMP  = 9'b000000100,
        ST_BCOPY = 9'b000001000,
        ST_BFALL = 9'b000010000,
        ST_START = 9'b000100000,
        ST_SCMP  = 9'b001000000,
        ST_SFALL = 9'b010000000,
        ST_HOLD  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [LEN_W-1:0]      r_plen;
    logic [CFG_DATA_W-1:0] r_pat [4];
    logic [PAT_W-1:0]      w_pat;
    logic                  w_cfg_hit;

    // Search state.
    logic             r_built, n_built;
    logic             r_done, n_done;
    logic [LEN_W-1:0] r_match, n_match;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_idx, n_idx;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic             r_last, n_last;

    // Table builder indexes: i is the table slot, k the prefix length.
    logic [PIDX_W-1:0] r_bi, n_bi;
    logic [LEN_W-1:0]  r_bk, n_bk;

    // Output register and a pending result for when it is still occupied.
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word r_pend, n_pend;
    logic      w_load;
    t_out_word w_load_word;

    // Failure table memory port.
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [LEN_W-1:0] w_ram_wdata;
    logic [AW-1:0]    w_ram_raddr;
    logic [LEN_W-1:0] w_ram_rdata;

    logic [LEN_W-1:0] w_len;
    logic             w_in_acc;
    logic             w_out_free;

    // Helper values for the compare states.
    logic              w_first_now;
    logic              w_st_done;
    logic [LEN_W-1:0]  w_st_match;
    logic [POS_W-1:0]  w_st_pos;
    logic              w_hit;
    logic [LEN_W-1:0]  w_j1;
    logic [POS_W-1:0]  w_nm1;
    t_out_word         w_found_word;
    t_out_word         w_miss_word;
    logic              w_bhit;
    logic              w_bdiff;
    logic              w_bdone;
    logic [PIDX_W-1:0] w_bi1;
    logic [LEN_W-1:0]  w_bk1;

    assign w_pat = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    kps_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_PATTERN)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Effective pattern length: zero acts as one, too large clamps to the maximum.
    always_comb begin
        if (r_plen == '0) begin
            w_len = LEN_W'(1);
        end else if (r_plen > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = r_plen;
        end
    end

    always_comb begin
        unique case (i_cfg_idx) inside
            CFG_LENGTH, CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: w_cfg_hit = i_cfg_we;
            default: w_cfg_hit = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // A first-of-text byte clears the match state as it is accepted; when the
    // search starts in the same cycle it must see the cleared values.
    assign w_first_now = w_in_acc && i_in_word.first_of_text;
    assign w_st_done   = w_first_now ? 1'b0 : r_done;
    assign w_st_match  = w_first_now ? '0 : r_match;
    assign w_st_pos    = w_first_now ? '0 : r_pos;

    // Text compare.
    assign w_hit = (r_match == K_RESTART) || (r_byte == pat_byte(w_pat, r_match[PIDX_W-1:0]));
    assign w_j1  = r_match + LEN_W'(1);
    assign w_nm1 = POS_W'(w_len - LEN_W'(1));
    assign w_found_word.found       = 1'b1;
    assign w_found_word.match_start = (r_idx >= w_nm1) ? (r_idx - w_nm1) : '0;
    assign w_miss_word.found        = 1'b0;
    assign w_miss_word.match_start  = '0;

    // Table build compare.
    assign w_bi1   = r_bi + PIDX_W'(1);
    assign w_bk1   = r_bk + LEN_W'(1);
    assign w_bdone = (LEN_W'(r_bi) + LEN_W'(1)) >= w_len;
    assign w_bhit  = (r_bk == K_RESTART) ||
                     (pat_byte(w_pat, r_bi) == pat_byte(w_pat, r_bk[PIDX_W-1:0]));
    assign w_bdiff = pat_byte(w_pat, w_bi1) != pat_byte(w_pat, w_bk1[PIDX_W-1:0]);

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_done      = r_done;
        n_match     = r_match;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_byte      = r_byte;
        n_last      = r_last;
        n_bi        = r_bi;
        n_bk        = r_bk;
        n_pend      = r_pend;
        w_load      = 1'b0;
        w_load_word = r_pend;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        w_ram_raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_byte  = i_in_word.text_byte;
                    n_last  = i_in_word.last_of_text;
                    n_done  = w_st_done;
                    n_match = w_st_match;
                    n_pos   = w_st_pos;
                    if (i_in_word.first_of_text || !r_built) begin
                        n_state = ST_BINIT;
                    end else if (!w_st_done) begin
                        n_match = (w_st_match >= w_len) ? '0 : w_st_match;
                        n_idx   = w_st_pos;
                        n_pos   = (w_st_pos < POS_LIMIT) ? w_st_pos + POS_W'(1) : w_st_pos;
                        n_state = ST_SCMP;
                    end
                end
            end
            ST_BINIT: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = '0;
                w_ram_wdata = K_RESTART;
                n_bi        = '0;
                n_bk        = K_RESTART;
                n_state     = ST_BCMP;
            end
            ST_BCMP: begin
                if (w_bdone) begin
                    n_built = 1'b1;
                    n_state = ST_START;
                end else if (w_bhit) begin
                    n_bi = w_bi1;
                    n_bk = w_bk1;
                    if (w_bdiff) begin
                        w_ram_we    = 1'b1;
                        w_ram_waddr = w_bi1[AW-1:0];
                        w_ram_wdata = w_bk1;
                    end else begin
                        // Equal bytes inherit the link of the shorter prefix.
                        w_ram_raddr = w_bk1[AW-1:0];
                        n_state     = ST_BCOPY;
                    end
                end else begin
                    w_ram_raddr = r_bk[AW-1:0];
                    n_state     = ST_BFALL;
                end
            end
            ST_BCOPY: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_bi[AW-1:0];
                w_ram_wdata = w_ram_rdata;
                n_state     = ST_BCMP;
            end
            ST_BFALL: begin
                n_bk    = w_ram_rdata;
                n_state = ST_BCMP;
            end
            ST_START: begin
                if (r_done) begin
                    n_state = ST_IDLE;
                end else begin
                    n_match = (r_match >= w_len) ? '0 : r_match;
                    n_idx   = r_pos;
                    n_pos   = (r_pos < POS_LIMIT) ? r_pos + POS_W'(1) : r_pos;
                    n_state = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (w_hit) begin
                    n_state = ST_IDLE;
                    if (w_j1 >= w_len) begin
                        n_done      = 1'b1;
                        n_match     = '0;
                        w_load_word = w_found_word;
                    end else begin
                        n_match     = w_j1;
                        n_done      = r_last;
                        w_load_word = w_miss_word;
                    end
                    if ((w_j1 >= w_len) || r_last) begin
                        if (w_out_free) begin
                            w_load = 1'b1;
                        end else begin
                            n_pend  = w_load_word;
                            n_state = ST_HOLD;
                        end
                    end
                end else begin
                    w_ram_raddr = r_match[AW-1:0];
                    n_state     = ST_SFALL;
                end
            end
            ST_SFALL: begin
                n_match = w_ram_rdata;
                n_state = ST_SCMP;
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Any register write invalidates the table.
        if (w_cfg_hit) begin
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_done      <= 1'b0;
            r_match     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;
            r_done  <= n_done;
            r_match <= n_match;
            r_pos   <= n_pos;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_byte <= n_byte;
        r_last <= n_last;
        r_bi   <= n_bi;
        r_bk   <= n_bk;
        r_pend <= n_pend;
        if (w_load) begin
            r_out <= w_load_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= LEN_W'(1);
            r_pat  <= '{default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LENGTH: r_plen   <= i_cfg_data[LEN_W-1:0];
                CFG_PAT0:   r_pat[0] <= i_cfg_data;
                CFG_PAT1:   r_pat[1] <= i_cfg_data;
                CFG_PAT2:   r_pat[2] <= i_cfg_data;
                CFG_PAT3:   r_pat[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* sv/kps_checker.sv */
// Port-level checker for the KMP pattern search unit, with its bind statement.
module kps_checker
    import kps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // A not-found result always reports start position zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |-> o_out_word.match_start == '0)
        else $error("not-found result with nonzero start");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Reset leaves the unit ready for a new text byte.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind kmp_pattern_search_unit kps_checker u_kps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

/* verif/kmp_pattern_search_unit_tb.sv */
// Self-checking testbench for the streaming KMP pattern search unit.
`timescale 1ns / 1ps

module kmp_pattern_search_unit_tb;
    import kps_pkg::*;

    // Position counter stops at the top of the 16-bit range.
    localparam int unsigned POS_LIMIT = (1 << POS_W) - 1;
    localparam int DIR_ROWS = 24;
    localparam int RANDOM_WORDS = 2000;
    // Quiet cycles before a register write or the final verdict. Covers a
    // full table rebuild for a 32-byte pattern plus a compare with links.
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_MAX = '1;

    // One row of the directed table: either a register write or a text word.
    // Rows marked typed carry a result that is obvious by inspection.
    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in_word              word;
        bit                    typed;
        t_out_word             want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_word              in_word = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kmp_pattern_search_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the unit's registers and search state.
    logic [LEN_W-1:0]      len_reg = 6'd1;
    logic [CFG_DATA_W-1:0] pat_reg [4] = '{default: '0};
    int                    fail_link [PAT_BYTES];
    int                    match_len = 0;
    int unsigned           text_pos = 0;
    bit                    text_done = 1'b0;
    bit                    links_valid = 1'b0;

    t_out_word pending_results [$];
    t_in_word  text_q [$];
    int        errors = 0;
    int        sent_count = 0;
    int        idle_pct = 16;
    int        stall_pct = 16;
    int        quiet_cycles = 0;
    logic [7:0] alpha_base;
    int         alpha_span;

    function automatic int eff_len();
        int n;
        n = int'(len_reg);
        if (n < 1) n = 1;
        if (n > PAT_BYTES) n = PAT_BYTES;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_at(int i);
        int u;
        u = i & 31;
        return pat_reg[u >> 3][(u & 7) * 8 +: 8];
    endfunction

    // Optimized failure links (nextval): a link that would land on the
    // same byte is collapsed to that byte's own link.
    function automatic void rebuild_links();
        int n, i, k;
        n = eff_len();
        i = 0;
        k = -1;
        fail_link[0] = -1;
        while (i < n - 1) begin
            if (k == -1 || pat_at(i) == pat_at(k)) begin
                i++;
                k++;
                if (pat_at(i) != pat_at(k)) fail_link[i & 31] = k;
                else fail_link[i & 31] = fail_link[k & 31];
            end else begin
                k = fail_link[k & 31];
            end
        end
        links_valid = 1'b1;
    endfunction

    function automatic void note_reg_write(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx) inside
            CFG_LENGTH: len_reg = val[LEN_W-1:0];
            CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: pat_reg[idx - CFG_PAT0] = val;
            default: return;
        endcase
        links_valid = 1'b0;
    endfunction

    // Advances the shadow search by one text word. Returns 1 when the word
    // produces a result.
    function automatic bit search_step(input t_in_word w, output t_out_word res);
        int n, j;
        int unsigned idx;
        res = '0;
        if (w.first_of_text) begin
            match_len = 0;
            text_pos = 0;
            text_done = 1'b0;
        end
        if (w.first_of_text || !links_valid) rebuild_links();
        if (text_done) return 1'b0;
        n = eff_len();
        if (match_len >= n) match_len = 0;
        idx = text_pos;
        if (text_pos < POS_LIMIT) text_pos++;
        j = match_len;
        while (!(j == -1 || w.text_byte == pat_at(j))) j = fail_link[j & 31];
        j++;
        match_len = j;
        if (j >= n) begin
            text_done = 1'b1;
            match_len = 0;
            res.found = 1'b1;
            res.match_start = (idx >= n - 1) ? POS_W'(idx - (n - 1)) : '0;
            return 1'b1;
        end
        if (w.last_of_text) begin
            text_done = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row word_row(logic [7:0] b, bit f, bit l);
        t_dir_row r;
        r = '0;
        r.word = '{text_byte: b, first_of_text: f, last_of_text: l};
        return r;
    endfunction

    function automatic t_dir_row typed_row(logic [7:0] b, bit f, bit l, bit found,
                                           logic [POS_W-1:0] start);
        t_dir_row r;
        r = word_row(b, f, l);
        r.typed = 1'b1;
        r.want = '{found: found, match_start: start};
        return r;
    endfunction

    // Presents one word, with random idle cycles in front, and runs the
    // shadow search at the edge where the unit takes it.
    task automatic send_word(input t_in_word w, output bit got, output t_out_word res);
        cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        got = search_step(w, res);
        sent_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        note_reg_write(idx, val);
    endtask

    // Waits until every predicted result has come back, then lets the unit
    // finish any word that produces no result.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random pattern setting. Most patterns are short and drawn from a
    // small alphabet so that texts match often.
    task automatic pick_setting();
        logic [LEN_W-1:0]      len_raw;
        logic [CFG_DATA_W-1:0] len_word;
        logic [CFG_DATA_W-1:0] pat_word;
        int                    mode;
        bit                    wild;
        mode = $urandom_range(0, 9);
        if (mode < 6) len_raw = LEN_W'($urandom_range(1, 8));
        else if (mode == 6) len_raw = LEN_W'($urandom_range(9, 31));
        else if (mode == 7) len_raw = LEN_W'(PAT_BYTES);
        else if (mode == 8) len_raw = $urandom_range(0, 1) ? '1 : '0;
        else len_raw = LEN_W'($urandom);
        alpha_base = 8'($urandom);
        alpha_span = $urandom_range(1, 3);
        wild = ($urandom_range(0, 7) == 0);
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len_raw;
        write_reg(CFG_LENGTH, len_word);
        for (int r = 0; r < 4; r++) begin
            for (int b = 0; b < 8; b++) begin
                pat_word[b * 8 +: 8] = wild ? 8'($urandom)
                                            : 8'(alpha_base + $urandom_range(0, alpha_span - 1));
            end
            write_reg(CFG_IDX_W'(CFG_PAT0 + r), pat_word);
        end
        // An unused index must leave the pattern and the table alone.
        if ($urandom_range(0, 5) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_PAT3 + 1, CFG_SPARE_MAX)),
                      {$urandom, $urandom});
        end
    endtask

    // Builds one text into text_q. Most texts are well formed and about half
    // carry a planted copy of the pattern; the rest have random markers.
    task automatic make_text();
        int n, len, plant_at;
        bit tidy;
        t_in_word w;
        n = eff_len();
        len = $urandom_range(1, 3 * n + 8);
        tidy = ($urandom_range(0, 99) < 85);
        plant_at = ($urandom_range(0, 1) && len >= n) ? $urandom_range(0, len - n) : -1;
        for (int b = 0; b < len; b++) begin
            if (plant_at >= 0 && b >= plant_at && b < plant_at + n)
                w.text_byte = pat_at(b - plant_at);
            else if ($urandom_range(0, 9) != 0)
                w.text_byte = 8'(alpha_base + $urandom_range(0, alpha_span - 1));
            else
                w.text_byte = 8'($urandom);
            if (tidy) begin
                w.first_of_text = (b == 0);
                w.last_of_text = (b == len - 1);
            end else begin
                w.first_of_text = ($urandom_range(0, 9) == 0);
                w.last_of_text = ($urandom_range(0, 9) == 0);
            end
            text_q.push_back(w);
        end
    endtask

    // Receiver side: random stall cycles on the result channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every result word taken is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, found=%0b match_start=%0d",
                         $time, out_word.found, out_word.match_start);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_word.found !== want.found) begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, out_word.found);
                    errors++;
                end
                if (out_word.match_start !== want.match_start) begin
                    $display("%0t: match_start mismatch, expected %0d, actual %0d",
                             $time, want.match_start, out_word.match_start);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel nor the write port moves.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_results.size());
            $display("kmp_pattern_search_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row   dir_rows [DIR_ROWS];
        t_out_word  res;
        bit         got;
        bit         prev_cfg;
        int         budget;

        // Directed part. After reset the pattern is one zero byte and the
        // table is not built yet, so the very first word must build it even
        // without a first-of-text mark.
        dir_rows = '{
            typed_row(8'h00, 1'b0, 1'b0, 1'b1, 16'd0),
            // A word after a result is absorbed until the next text.
            word_row (8'hFF, 1'b0, 1'b1),
            typed_row(8'hFF, 1'b1, 1'b1, 1'b0, 16'd0),
            // Length 0 behaves as length 1; upper data bits are ignored.
            cfg_row  (CFG_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0),
            cfg_row  (CFG_PAT0, 64'hFFFF_FFFF_FFFF_FFFF),
            typed_row(8'hFF, 1'b1, 1'b1, 1'b1, 16'd0),
            // Pattern "aab" inside "aaab": one failure link is followed.
            cfg_row  (CFG_LENGTH, 64'd3),
            cfg_row  (CFG_PAT0, 64'h0000_0000_0062_6161),
            word_row (8'h61, 1'b1, 1'b0),
            word_row (8'h61, 1'b0, 1'b0),
            word_row (8'h61, 1'b0, 1'b0),
            typed_row(8'h62, 1'b0, 1'b0, 1'b1, 16'd1),
            word_row (8'h62, 1'b0, 1'b1),
            // Match on the last word: only the match is reported.
            word_row (8'h61, 1'b1, 1'b0),
            word_row (8'h61, 1'b0, 1'b0),
            typed_row(8'h62, 1'b0, 1'b1, 1'b1, 16'd0),
            // Pattern shortened in the middle of a text that then continues
            // without a first mark.
            word_row (8'h61, 1'b1, 1'b0),
            word_row (8'h61, 1'b0, 1'b0),
            cfg_row  (CFG_LENGTH, 64'd2),
            word_row (8'h61, 1'b0, 1'b0),
            word_row (8'h61, 1'b0, 1'b1),
            // Length 63 clamps to 32; a one-word text cannot match it.
            cfg_row  (CFG_LENGTH, 64'h3F),
            cfg_row  (CFG_PAT3, 64'h8000_0000_0000_0000),
            typed_row(8'h00, 1'b1, 1'b1, 1'b0, 16'd0)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].is_cfg) begin
                if (!prev_cfg) settle();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                send_word(dir_rows[r].word, got, res);
                if (dir_rows[r].typed) pending_results.push_back(dir_rows[r].want);
                else if (got) pending_results.push_back(res);
            end
            prev_cfg = dir_rows[r].is_cfg;
        end

        // Random part: phases of one pattern setting each. A phase may end
        // in the middle of a text, so the next one continues that text under
        // a new pattern. One stretch runs with no idle and no stall cycles.
        while (sent_count < RANDOM_WORDS) begin
            settle();
            idle_pct = (sent_count >= 800 && sent_count < 1100) ? 0 : 16;
            stall_pct = idle_pct;
            pick_setting();
            budget = $urandom_range(20, 150);
            while (budget > 0) begin
                text_q.delete();
                make_text();
                while (budget > 0 && text_q.size() != 0) begin
                    send_word(text_q.pop_front(), got, res);
                    if (got) pending_results.push_back(res);
                    budget--;
                end
            end
        end

        settle();
        if (errors == 0) begin
            $display("kmp_pattern_search_unit_tb: done, clean");
        end else begin
            $display("kmp_pattern_search_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
